### rtl/gdc_pkg.sv
// ----------------------------------------------------------------------------
// gdc_pkg
// Shared types and constants for the greedy defective coloring engine.
// ----------------------------------------------------------------------------
package gdc_pkg;

   localparam int NODES_MAX = 64;
   localparam int MASK_W    = 64;
   localparam int LABEL_W   = 6;
   localparam int SIZE_W    = 7;
   localparam int DEG_W     = 6;
   localparam int COUNT_W   = 7;
   localparam int STATUS_W  = 2;

   localparam logic [STATUS_W-1:0] STATUS_PLACED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CLEARED = 2'd2;

   localparam logic OP_CLEAR = 1'b0;
   localparam logic OP_PLACE = 1'b1;

   // One class as held by a cell: stable label, member set and size.
   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic [MASK_W-1:0]  members;
      logic [SIZE_W-1:0]  size;
   } gdc_rec_type;

   // Per-cell control from the sequencer.
   typedef struct packed {
      logic clear;
      logic tok_shift;
      logic take_left;
      logic take_right;
      logic load;
      logic set_occ;
   } gdc_cell_ctl_type;

endpackage

### rtl/gdc_cell.sv
// ----------------------------------------------------------------------------
// gdc_cell
// One slot of the size-ordered class chain, with its scan token.
// ----------------------------------------------------------------------------
module gdc_cell import gdc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  gdc_cell_ctl_type ctl,
   input  logic             tok_in,
   input  gdc_rec_type      left_rec,
   input  gdc_rec_type      right_rec,
   input  gdc_rec_type      load_rec,
   output gdc_rec_type      rec,
   output logic             occ,
   output logic             tok
);

   gdc_rec_type rec_ff;
   logic        occ_ff;
   logic        tok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
         tok_ff <= 1'b0;
      end else begin
         if (ctl.clear) begin
            occ_ff <= 1'b0;
         end else if (ctl.set_occ) begin
            occ_ff <= 1'b1;
         end
         if (ctl.tok_shift) begin
            tok_ff <= tok_in;
         end
      end
   end

   // A class slides in from a neighbor or is loaded from the sequencer.
   always_ff @(posedge clock) begin
      if (ctl.take_right) begin
         rec_ff <= right_rec;
      end else if (ctl.take_left) begin
         rec_ff <= left_rec;
      end else if (ctl.load) begin
         rec_ff <= load_rec;
      end
   end

   assign rec = rec_ff;
   assign occ = occ_ff;
   assign tok = tok_ff;

endmodule

### rtl/greedy_defective_coloring.sv
// ----------------------------------------------------------------------------
// greedy_defective_coloring
// Greedy k-defective graph coloring engine built on a chain of class cells.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Contents
//   req_     in         req_valid/req_stall   opcode, node index, neighbor mask
//   rsp_     out        rsp_valid/rsp_stall   status, label, new flag, degree, count
//   csr_     in         csr_valid/csr_ready   defect limit k
//
// A clear or an ignored request goes from idle straight to emit. A placement
// goes through scan, commit and emit. The scan token moves one cell per cycle
// while its cell holds a class that does not fit; one shared fit test
// evaluates the cell it sits on. One request is worked on at a time.
// Reset is synchronous and leaves no classes, no placed nodes and k = 0.
// The result waits in an output register while rsp_stall is high; a new
// request is taken once the previous result has been moved to that register.
//
module greedy_defective_coloring import gdc_pkg::*; #(
   parameter int MAX_NODES = NODES_MAX
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_opcode,
   input  logic [5:0]          req_node_index,
   input  logic [MASK_W-1:0]   req_neighbor_mask,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [LABEL_W-1:0]  rsp_class_label,
   output logic                rsp_new_class,
   output logic [DEG_W-1:0]    rsp_neighbors_in_class,
   output logic [COUNT_W-1:0]  rsp_class_count,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [DEG_W-1:0]    csr_defect_limit
);

   localparam int N = MAX_NODES;
   // Nodes that exist in this configuration.
   localparam logic [MASK_W-1:0] NODE_MASK =
      (N >= MASK_W) ? {MASK_W{1'b1}} : ((64'd1 << N) - 64'd1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_COMMIT = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [DEG_W-1:0]   k_ff;
   logic [COUNT_W-1:0] num_ff;
   logic [MASK_W-1:0]  placed_ff;
   logic [DEG_W-1:0]   deg_ff [N];

   // Request being placed.
   logic [5:0]         node_ff;
   logic [MASK_W-1:0]  nbit_ff;
   logic [MASK_W-1:0]  mask_ff;

   // Class that accepted the node during the scan.
   logic               found_ff;
   logic [LABEL_W-1:0] hit_label_ff;
   logic [MASK_W-1:0]  hit_members_ff;
   logic [SIZE_W-1:0]  hit_size_ff;
   logic [MASK_W-1:0]  hit_adj_ff;
   logic [DEG_W-1:0]   hit_cnt_ff;

   // Pending result and output register.
   logic [STATUS_W-1:0] res_status_ff;
   logic [LABEL_W-1:0]  res_label_ff;
   logic                res_new_ff;
   logic [DEG_W-1:0]    res_deg_ff;
   logic [COUNT_W-1:0]  res_count_ff;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [LABEL_W-1:0]  rsp_label_ff;
   logic                rsp_new_ff;
   logic [DEG_W-1:0]    rsp_deg_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   // Chain signals.
   gdc_rec_type      rec_v [N];
   gdc_cell_ctl_type ctl_v [N];
   logic [N-1:0]     occ_v, tok_v, tok_in_v;
   logic [N-1:0]     after_v, move_v, big_v, newpos_v;
   gdc_rec_type      load_rec;

   logic req_acc, rsp_free, start, step, commit_hit, commit_new, do_clear;
   logic ignored;
   logic [MASK_W-1:0]  nbit_c;
   logic [MASK_W-1:0]  sat_c, adj_c;
   logic [COUNT_W-1:0] cnt_c;
   logic               cur_occ, fit;
   gdc_rec_type        sel_rec;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign nbit_c  = 64'd1 << req_node_index;
   assign ignored = (7'(req_node_index) >= 7'(N)) || ((placed_ff & nbit_c) != '0);

   assign do_clear   = req_acc && (req_opcode == OP_CLEAR);
   assign start      = req_acc && (req_opcode == OP_PLACE) && !ignored;
   assign commit_hit = (state_ff == ST_COMMIT) && found_ff;
   assign commit_new = (state_ff == ST_COMMIT) && !found_ff;

   // Selected cell under the token; an empty selection means no class fits.
   always_comb begin
      sel_rec = '0;
      for (int i = 0; i < N; i++) begin
         if (tok_v[i]) begin
            sel_rec = sel_rec | rec_v[i];
         end
      end
   end
   assign cur_occ = (tok_v & occ_v) != '0;

   // A node is saturated once its inner degree has reached k.
   always_comb begin
      sat_c = '0;
      for (int i = 0; i < N; i++) begin
         sat_c[i] = (deg_ff[i] >= k_ff);
      end
   end

   assign adj_c = mask_ff & sel_rec.members;
   assign cnt_c = COUNT_W'($countones(adj_c));
   assign fit   = cur_occ && (cnt_c <= {1'b0, k_ff}) && ((adj_c & sat_c) == '0);
   assign step  = (state_ff == ST_SCAN) && cur_occ && !fit;

   // Re-sort bookkeeping. After a hit the grown class slides right past the
   // classes of its old size; a new class slides left past every class
   // larger than one. Both keep equal sizes in their earlier order.
   assign after_v  = ~((tok_v << 1) - N'(1));
   assign newpos_v = ~occ_v & {occ_v[N-2:0], 1'b1};
   always_comb begin
      for (int i = 0; i < N; i++) begin
         move_v[i] = occ_v[i] && after_v[i] && (rec_v[i].size == hit_size_ff);
         big_v[i]  = occ_v[i] && (rec_v[i].size > SIZE_W'(1));
      end
   end

   always_comb begin
      if (found_ff) begin
         load_rec.label   = hit_label_ff;
         load_rec.members = hit_members_ff | nbit_ff;
         load_rec.size    = hit_size_ff + SIZE_W'(1);
      end else begin
         load_rec.label   = num_ff[LABEL_W-1:0];
         load_rec.members = nbit_ff;
         load_rec.size    = SIZE_W'(1);
      end
   end

   for (genvar g = 0; g < N; g++) begin : g_cell
      logic        mv_next, big_prev, here;
      gdc_rec_type left_rec, right_rec;

      if (g == N - 1) begin : g_last
         assign mv_next   = 1'b0;
         assign right_rec = rec_v[g];
      end else begin : g_mid
         assign mv_next   = move_v[g+1];
         assign right_rec = rec_v[g+1];
      end
      if (g == 0) begin : g_head
         assign big_prev    = 1'b0;
         assign left_rec    = rec_v[g];
         assign tok_in_v[g] = start;
      end else begin : g_body
         assign big_prev    = big_v[g-1];
         assign left_rec    = rec_v[g-1];
         assign tok_in_v[g] = !start && tok_v[g-1];
      end

      assign here = tok_v[g] || move_v[g];
      assign ctl_v[g].clear      = do_clear;
      assign ctl_v[g].tok_shift  = start || step;
      assign ctl_v[g].take_right = commit_hit && here && mv_next;
      assign ctl_v[g].take_left  = commit_new && big_prev && (big_v[g] || newpos_v[g]);
      assign ctl_v[g].load       = (commit_hit && here && !mv_next) ||
                                   (commit_new && (big_v[g] || newpos_v[g]) && !big_prev);
      assign ctl_v[g].set_occ    = commit_new && newpos_v[g];

      gdc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl_v[g]),
         .tok_in    (tok_in_v[g]),
         .left_rec  (left_rec),
         .right_rec (right_rec),
         .load_rec  (load_rec),
         .rec       (rec_v[g]),
         .occ       (occ_v[g]),
         .tok       (tok_v[g])
      );
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = start ? ST_SCAN : ST_EMIT;
            end
         end
         ST_SCAN: begin
            if (!cur_occ || fit) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state: k, class count, placed set, inner degrees.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         num_ff       <= '0;
         placed_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < N; i++) begin
            deg_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            k_ff <= csr_defect_limit;
         end
         if (do_clear) begin
            num_ff    <= '0;
            placed_ff <= '0;
            for (int i = 0; i < N; i++) begin
               deg_ff[i] <= '0;
            end
         end else if (state_ff == ST_COMMIT) begin
            placed_ff <= placed_ff | nbit_ff;
            if (!found_ff) begin
               num_ff <= num_ff + COUNT_W'(1);
            end
            for (int i = 0; i < N; i++) begin
               if (6'(i) == node_ff) begin
                  deg_ff[i] <= found_ff ? hit_cnt_ff : '0;
               end else if (found_ff && hit_adj_ff[i] && (deg_ff[i] != '1)) begin
                  deg_ff[i] <= deg_ff[i] + DEG_W'(1);
               end
            end
         end
         if (state_ff == ST_EMIT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         node_ff       <= req_node_index;
         nbit_ff       <= nbit_c;
         mask_ff       <= req_neighbor_mask & NODE_MASK & ~nbit_c;
         res_status_ff <= (req_opcode == OP_CLEAR) ? STATUS_CLEARED : STATUS_IGNORED;
         res_label_ff  <= '0;
         res_new_ff    <= 1'b0;
         res_deg_ff    <= '0;
         res_count_ff  <= (req_opcode == OP_CLEAR) ? '0 : num_ff;
      end
      if (state_ff == ST_SCAN) begin
         found_ff <= fit;
         if (fit) begin
            hit_label_ff   <= sel_rec.label;
            hit_members_ff <= sel_rec.members;
            hit_size_ff    <= sel_rec.size;
            hit_adj_ff     <= adj_c;
            hit_cnt_ff     <= cnt_c[DEG_W-1:0];
         end
      end
      if (state_ff == ST_COMMIT) begin
         res_status_ff <= STATUS_PLACED;
         res_label_ff  <= found_ff ? hit_label_ff : num_ff[LABEL_W-1:0];
         res_new_ff    <= !found_ff;
         res_deg_ff    <= found_ff ? hit_cnt_ff : '0;
         res_count_ff  <= found_ff ? num_ff : num_ff + COUNT_W'(1);
      end
      if (state_ff == ST_EMIT && rsp_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_label_ff  <= res_label_ff;
         rsp_new_ff    <= res_new_ff;
         rsp_deg_ff    <= res_deg_ff;
         rsp_count_ff  <= res_count_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_class_label        = rsp_label_ff;
   assign rsp_new_class          = rsp_new_ff;
   assign rsp_neighbors_in_class = rsp_deg_ff;
   assign rsp_class_count        = rsp_count_ff;

endmodule

### rtl/gdc_checker.sv
// ----------------------------------------------------------------------------
// gdc_checker
// Port-level checks on the result channel of the coloring engine.
// ----------------------------------------------------------------------------
module gdc_checker import gdc_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [LABEL_W-1:0]  rsp_class_label,
   input logic                rsp_new_class,
   input logic [DEG_W-1:0]    rsp_neighbors_in_class,
   input logic [COUNT_W-1:0]  rsp_class_count
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its label and count.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_class_label) && $stable(rsp_class_count))
      else $error("result changed while stalled");

   // A cleared run reports no classes.
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_CLEARED |-> rsp_class_count == '0)
      else $error("clear reported classes");

   // A placed node lands in an existing class label.
   a_label_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_PLACED |->
         rsp_class_count != '0 && COUNT_W'(rsp_class_label) < rsp_class_count)
      else $error("label outside class count");

   // A newly opened class is the last label and holds no neighbors.
   a_new_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_class |->
         rsp_status == STATUS_PLACED && rsp_neighbors_in_class == '0 &&
         COUNT_W'(rsp_class_label) == rsp_class_count - COUNT_W'(1))
      else $error("bad new class result");

endmodule

bind greedy_defective_coloring gdc_checker u_gdc_checker (.*);

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the greedy defective coloring engine. A directed
// table of requests runs first, then randomized runs of node placements with
// random neighbor masks under several defect limits. Every response is checked
// against a behavioral model of the coloring kept inside this module.
// ----------------------------------------------------------------------------
module tb import gdc_pkg::*; ;

   timeunit 1ns;
   timeprecision 1ps;

   // One response as the engine reports it.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [LABEL_W-1:0]  label;
      logic                fresh;
      logic [DEG_W-1:0]    degree;
      logic [COUNT_W-1:0]  count;
   } coloring_rsp_type;

   // One row of the directed table. When has_gold is set, the typed-in
   // response is compared with the model's response as a sanity check.
   typedef struct {
      logic                op;
      logic [5:0]          node;
      logic [MASK_W-1:0]   mask;
      bit                  has_gold;
      coloring_rsp_type    gold;
   } directed_row_type;

   localparam int HALF_PERIOD = 6;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int RANDOM_ITEMS = 1050;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_opcode = OP_CLEAR;
   logic [5:0]          req_node_index = '0;
   logic [MASK_W-1:0]   req_neighbor_mask = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [LABEL_W-1:0]  rsp_class_label;
   logic                rsp_new_class;
   logic [DEG_W-1:0]    rsp_neighbors_in_class;
   logic [COUNT_W-1:0]  rsp_class_count;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [DEG_W-1:0]    csr_defect_limit = '0;

   greedy_defective_coloring dut (.*);

   always #HALF_PERIOD clock = ~clock;

   // Model state: a copy of the coloring as the engine should hold it.
   logic [DEG_W-1:0]   k_limit;
   logic [MASK_W-1:0]  members[64];
   int unsigned        csize[64];
   logic [LABEL_W-1:0] order[64];
   int unsigned        inner[64];
   logic [MASK_W-1:0]  placed;
   int unsigned        nclass;

   coloring_rsp_type pending_rsps[$];
   int               errors = 0;
   longint           cycles = 0;
   bit               long_hold = 1'b0;  // receiver holds off while set
   int               stall_mode = 0;    // 0 random, 1 never stall

   task automatic report(input string what, input coloring_rsp_type got,
                         input coloring_rsp_type want);
      $display("mismatch %s: got %p want %p at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic void clear_coloring();
      for (int i = 0; i < 64; i++) begin
         members[i] = '0;
         csize[i] = 0;
         order[i] = '0;
         inner[i] = 0;
      end
      placed = '0;
      nclass = 0;
   endfunction

   // Computes the response of one request and advances the model.
   function automatic coloring_rsp_type color_node(input logic op, input logic [5:0] node,
                                                   input logic [MASK_W-1:0] mask_in);
      coloring_rsp_type   r;
      logic [MASK_W-1:0]  nb, mask, sat, adj;
      logic [LABEL_W-1:0] lab, pick;
      int unsigned        cnt, deg, j;
      bit                 found;
      r = '0;
      found = 0;
      pick = '0;
      deg = 0;
      if (op == OP_CLEAR) begin
         clear_coloring();
         r.status = STATUS_CLEARED;
         return r;
      end
      nb = 64'd1 << node;
      if ((placed & nb) != '0) begin
         r.status = STATUS_IGNORED;
         r.count = COUNT_W'(nclass);
         return r;
      end
      mask = mask_in & ~nb;
      sat = '0;
      for (int i = 0; i < 64; i++)
         if (inner[i] >= k_limit) sat[i] = 1'b1;
      for (int p = 0; p < nclass && !found; p++) begin
         lab = order[p];
         adj = mask & members[lab];
         cnt = $countones(adj);
         if (cnt <= k_limit && (adj & sat) == '0) begin
            found = 1;
            pick = lab;
            deg = cnt;
            for (int i = 0; i < 64; i++)
               if (adj[i] && inner[i] < 63) inner[i]++;
         end
      end
      if (!found) begin
         pick = LABEL_W'(nclass);
         order[nclass] = pick;
         nclass++;
         deg = 0;
         r.fresh = 1'b1;
      end
      members[pick] |= nb;
      csize[pick]++;
      inner[node] = deg;
      placed |= nb;
      // Stable insertion sort by size, smallest first.
      for (int i = 1; i < nclass; i++) begin
         lab = order[i];
         j = i;
         while (j > 0 && csize[order[j-1]] > csize[lab]) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = lab;
      end
      r.status = STATUS_PLACED;
      r.label = pick;
      r.degree = DEG_W'(deg);
      r.count = COUNT_W'(nclass);
      return r;
   endfunction

   // Cycle counter with the run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Response checker: each accepted response against the oldest expectation.
   always @(posedge clock) begin
      coloring_rsp_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_status, rsp_class_label, rsp_new_class,
                 rsp_neighbors_in_class, rsp_class_count};
         if (pending_rsps.size() == 0) begin
            report("unexpected response", got, '0);
         end else begin
            want = pending_rsps.pop_front();
            if (got.status !== want.status) report("status", got, want);
            if (got.label !== want.label) report("class_label", got, want);
            if (got.fresh !== want.fresh) report("new_class", got, want);
            if (got.degree !== want.degree) report("neighbors_in_class", got, want);
            if (got.count !== want.count) report("class_count", got, want);
         end
      end
   end

   // Receiver side: random stalls, mostly short, some long; a forced long
   // hold-off when the stimulus asks for it.
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
         end else if (stall_mode == 1) begin
            rsp_stall <= 1'b0;
         end else begin
            n = $urandom_range(0, 99);
            if (n < 60) rsp_stall <= 1'b0;
            else if (n < 95) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(0, 3)) @(posedge clock);
            end else begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(10, 60)) @(posedge clock);
            end
         end
      end
   end

   // Offers one request and waits until the engine takes it. The engine
   // stalls after each accepted request, so the wait before offering the next
   // one costs no throughput.
   task automatic send_request(input logic op, input logic [5:0] node,
                               input logic [MASK_W-1:0] mask, input bit gap);
      int n;
      @(posedge clock);
      if (gap) begin
         n = $urandom_range(0, 99);
         if (n >= 70 && n < 95) repeat ($urandom_range(1, 4)) @(posedge clock);
         else if (n >= 95) repeat ($urandom_range(10, 80)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_node_index <= node;
      req_neighbor_mask <= mask;
      pending_rsps.insert(pending_rsps.size(), color_node(op, node, mask));
      do @(posedge clock); while (req_stall);
      req_valid <= 1'b0;
   endtask

   // Waits for every outstanding response plus a little slack so the engine
   // is idle; write_limit uses it before it writes a new defect limit.
   task automatic drain();
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [DEG_W-1:0] k);
      drain();
      csr_valid <= 1'b1;
      csr_defect_limit <= k;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      k_limit = k;
   endtask

   // Random mask with bias: all-ones, all-zeros, sparse, or each bit set with the given density in percent.
   function automatic logic [MASK_W-1:0] pick_mask(input int density);
      logic [MASK_W-1:0] m;
      m = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: m = '1;
         1: m = '0;
         2, 3: m = m & {$urandom, $urandom} & {$urandom, $urandom};
         default: begin
            for (int i = 0; i < 64; i++)
               m[i] = ($urandom_range(0, 99) < density);
         end
      endcase
      return m;
   endfunction

   directed_row_type rows[$];
   coloring_rsp_type tmp;

   function automatic void add_row(input directed_row_type row);
      rows.insert(rows.size(), row);
   endfunction

   initial begin
      int sent, nodes, perm[64], t, r, dens;
      logic [DEG_W-1:0] limits[6] = '{6'd0, 6'd63, 6'd1, 6'd2, 6'd5, 6'd3};
      clear_coloring();
      k_limit = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, k = 0 right after reset. Gold responses are filled in
      // where they are obvious; other rows rely on the model alone.
      add_row('{OP_PLACE, 6'd0, '1, 1, '{STATUS_PLACED, 6'd0, 1'b1, 6'd0, 7'd1}});
      add_row('{OP_PLACE, 6'd0, '0, 1, '{STATUS_IGNORED, 6'd0, 1'b0, 6'd0, 7'd1}});
      add_row('{OP_PLACE, 6'd63, 64'h1, 1,
                '{STATUS_PLACED, 6'd1, 1'b1, 6'd0, 7'd2}});
      add_row('{OP_PLACE, 6'd5, 64'h0, 1, '{STATUS_PLACED, 6'd0, 1'b0, 6'd0, 7'd2}});
      // Own bit set in the mask is ignored.
      add_row('{OP_PLACE, 6'd7, 64'h80, 0, '0});
      add_row('{OP_PLACE, 6'd8, 64'hFFFF_FFFF_0000_0000, 0, '0});
      add_row('{OP_PLACE, 6'd63, '0, 1, '{STATUS_IGNORED, 6'd0, 1'b0, 6'd0, 7'd2}});
      add_row('{OP_CLEAR, 6'd63, '1, 1, '{STATUS_CLEARED, 6'd0, 1'b0, 6'd0, 7'd0}});
      add_row('{OP_PLACE, 6'd63, '0, 1, '{STATUS_PLACED, 6'd0, 1'b1, 6'd0, 7'd1}});
      add_row('{OP_CLEAR, 6'd0, '0, 0, '0});
      foreach (rows[i]) begin
         tmp = color_node(rows[i].op, rows[i].node, rows[i].mask);
         if (rows[i].has_gold && tmp !== rows[i].gold)
            report("directed gold", tmp, rows[i].gold);
      end
      clear_coloring();
      foreach (rows[i]) send_request(rows[i].op, rows[i].node, rows[i].mask, 1);

      // A complete graph of 12 nodes under k = 63: everything shares class 0
      // and inner degrees climb; then a path under k = 1.
      write_limit(6'd63);
      for (int i = 0; i < 12; i++) send_request(OP_PLACE, 6'(i), 64'hFFF, 1);
      send_request(OP_CLEAR, 6'd0, '0, 1);
      write_limit(6'd1);
      for (int i = 0; i < 10; i++)
         send_request(OP_PLACE, 6'(i),
                      (64'd1 << (i + 1)) | (i > 0 ? 64'd1 << (i - 1) : 64'd0), 1);

      // Pressure: the receiver holds off while requests keep coming.
      long_hold = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end
         for (int i = 10; i < 16; i++) send_request(OP_PLACE, 6'(i), pick_mask(30), 0);
      join

      // Random runs: each phase clears, then places a prefix of a node permutation,
      // with a few repeats; the limit changes between phases.
      sent = 0;
      t = 0;
      while (sent < RANDOM_ITEMS) begin
         write_limit(limits[t % 6]);
         stall_mode = (t % 4 == 3);
         t++;
         send_request(OP_CLEAR, 6'($urandom), {$urandom, $urandom}, 1);
         nodes = (t % 5 == 0) ? 64 : $urandom_range(2, 40);
         dens = $urandom_range(3, 70);
         for (int i = 0; i < 64; i++) perm[i] = i;
         for (int i = 63; i > 0; i--) begin
            r = $urandom_range(0, i);
            {perm[i], perm[r]} = {perm[r], perm[i]};
         end
         for (int i = 0; i < nodes; i++) begin
            if ($urandom_range(0, 19) == 0)
               send_request(OP_PLACE, 6'(perm[$urandom_range(0, i)]), pick_mask(dens), 1);
            send_request(OP_PLACE, 6'(perm[i]), pick_mask(dens), 1);
            sent++;
         end
      end

      // The sender pauses until every response is back, then finishes off.
      drain();
      send_request(OP_PLACE, 6'd0, '0, 0);
      stall_mode = 0;

      t = 0;
      while (pending_rsps.size() != 0 && t < 100000) begin
         @(posedge clock);
         t++;
      end
      repeat (100) @(posedge clock);
      if (errors == 0 && pending_rsps.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
